// ===== hdl/gbnsw_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbnsw_pkg
// Shared types, codes and defaults of the go-back-n sender window.
// ----------------------------------------------------------------------------
package gbnsw_pkg;

    // parameter defaults
    localparam int RING_DEPTH_DEF = 64;
    localparam int WINDOW_MAX_DEF = 32;

    // field widths
    localparam int SEQ_W     = 16;
    localparam int PAYLOAD_W = 16;
    localparam int TIME_W    = 16;
    localparam int WIN_W     = 6;
    localparam int ELAPSED_W = 17;
    localparam int FRAME_W   = PAYLOAD_W + 1;

    // stream packing
    localparam int S_TDATA_W = 48;
    localparam int S_TUSER_W = 3;
    localparam int M_TDATA_W = 32;
    localparam int M_TUSER_W = 2;

    // configuration
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_WINDOW_SIZE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT_MS  = 1'b1;
    localparam logic [WIN_W-1:0]     WINDOW_SIZE_RST = 6'd8;
    localparam logic [TIME_W-1:0]    TIMEOUT_MS_RST  = 16'd200;

    typedef enum logic [1:0] {
        MODE_ENQUEUE = 2'd0,
        MODE_ACK_RX  = 2'd1,
        MODE_TICK    = 2'd2,
        MODE_ACK_TX  = 2'd3
    } mode_t;

    typedef enum logic [1:0] {
        KIND_DATA    = 2'd0,
        KIND_FIN     = 2'd1,
        KIND_ACK     = 2'd2,
        KIND_REFUSED = 2'd3
    } kind_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DECODE,
        ST_FILL_CHK,
        ST_FILL_EMIT,
        ST_RS_RD,
        ST_RS_EMIT
    } state_t;

endpackage : gbnsw_pkg
`default_nettype wire

// ===== hdl/go_back_n_sender_window.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// go_back_n_sender_window
// Go-back-n sender: frame ring in memory, window fill, ack handling,
// retransmission timer and send records on the result stream.
// ----------------------------------------------------------------------------
//
//  channel   direction  word contents
//  s_*       in         tuser: mode, fin_flag / tdata: payload, ack_number, elapsed_ms
//  m_*       out        tuser: kind / tdata: seq_number, payload_out / tlast: last
//  cfg_*     in         register write, no read-back
//
//  an item is first accepted and then decoded; every frame sent by a window fill
//  or a resend costs a ring memory read, then an output register load, and a
//  fill closes with a final check that finds nothing more to send
//  no clearing pass after reset: ring entries are only read once written
//  the output register frees the input side, but a stalled m_tready holds the
//  sequencer on the frame it is about to deliver
//
module go_back_n_sender_window
    import gbnsw_pkg::*;
#(
    parameter int RING_DEPTH = RING_DEPTH_DEF,
    parameter int WINDOW_MAX = WINDOW_MAX_DEF
) (
    input  wire logic                  aclk,
    input  wire logic                  aresetn,
    // input words
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [S_TDATA_W-1:0]  s_tdata,   // payload, ack_number, elapsed_ms
    input  wire logic [S_TUSER_W-1:0]  s_tuser,   // mode, fin_flag
    // result words
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic      [M_TDATA_W-1:0]  m_tdata,   // seq_number, payload_out
    output logic      [M_TUSER_W-1:0]  m_tuser,   // kind
    output logic                       m_tlast,
    // configuration
    input  wire logic                  cfg_wr_en,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

    localparam int PTR_W = $clog2(RING_DEPTH);
    localparam int CNT_W = $clog2(RING_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam logic [6:0] WinMax = 7'(WINDOW_MAX);

    // ring index wrap: sums stay below twice the depth
    function automatic logic [PTR_W-1:0] wrap(input logic [SUM_W-1:0] s);
        logic [SUM_W-1:0] t;
        if (s >= SUM_W'(RING_DEPTH)) t = s - SUM_W'(RING_DEPTH);
        else                         t = s;
        return t[PTR_W-1:0];
    endfunction

    // control state
    state_t                state_reg,   state_next;
    logic [PTR_W-1:0]      head_reg,    head_next;
    logic [CNT_W-1:0]      count_reg,   count_next;
    logic [SEQ_W-1:0]      base_reg,    base_next;
    logic [SEQ_W-1:0]      nseq_reg,    nseq_next;
    logic [ELAPSED_W-1:0]  elapsed_reg, elapsed_next;
    logic                  running_reg, running_next;
    logic [CNT_W-1:0]      rs_idx_reg,  rs_idx_next;

    // configuration registers
    logic [WIN_W-1:0]      window_reg;
    logic [TIME_W-1:0]     timeout_reg;

    // latched input word
    mode_t                 mode_reg,    mode_next;
    logic [PAYLOAD_W-1:0]  pay_in_reg,  pay_in_next;
    logic                  fin_in_reg,  fin_in_next;
    logic [SEQ_W-1:0]      ack_in_reg,  ack_in_next;
    logic [TIME_W-1:0]     ms_in_reg,   ms_in_next;

    // output register
    logic                  m_valid_reg;
    kind_t                 m_kind_reg;
    logic [SEQ_W-1:0]      m_seq_reg;
    logic [PAYLOAD_W-1:0]  m_pay_reg;
    logic                  m_last_reg;

    logic                  out_load;
    kind_t                 out_kind;
    logic [SEQ_W-1:0]      out_seq;
    logic [PAYLOAD_W-1:0]  out_pay;
    logic                  out_last;
    logic                  out_free;

    // ring port
    logic                  mem_we;
    logic [PTR_W-1:0]      mem_waddr;
    logic                  mem_re;
    logic [PTR_W-1:0]      mem_raddr;
    logic [FRAME_W-1:0]    mem_rdata;

    // derived values
    logic [6:0]            win_eff;
    logic [SEQ_W-1:0]      outstanding;
    logic [SEQ_W-1:0]      ack_off;
    logic [CNT_W-1:0]      freed;
    logic [ELAPSED_W:0]    tick_sum;
    logic [ELAPSED_W-1:0]  tick_sat;
    logic [SEQ_W:0]        out_p1;
    logic                  fill_more;
    logic                  fill_cont;
    logic                  rs_last;

    gbnsw_ring #(
        .DEPTH  (RING_DEPTH),
        .ADDR_W (PTR_W),
        .DATA_W (FRAME_W)
    ) u_ring (
        .aclk    (aclk),
        .wr_en   (mem_we),
        .wr_addr (mem_waddr),
        .wr_data ({fin_in_reg, pay_in_reg}),
        .rd_en   (mem_re),
        .rd_addr (mem_raddr),
        .rd_data (mem_rdata)
    );

    // window size clamp: zero acts as one, large values as the maximum
    always_comb begin
        if (window_reg == '0)                 win_eff = 7'd1;
        else if ({1'b0, window_reg} > WinMax) win_eff = WinMax;
        else                                  win_eff = {1'b0, window_reg};
    end

    // sent but unacknowledged, never above the ring count
    assign outstanding = nseq_reg - base_reg;
    assign ack_off     = ack_in_reg - base_reg;
    assign freed       = ack_off[CNT_W-1:0] + CNT_W'(1);

    // timer advance with saturation
    assign tick_sum = {1'b0, elapsed_reg} + (ELAPSED_W+1)'(ms_in_reg);
    assign tick_sat = tick_sum[ELAPSED_W] ? '1 : tick_sum[ELAPSED_W-1:0];

    // window fill: send while below window and below ring count
    assign fill_more = (outstanding < SEQ_W'(win_eff)) && (outstanding < SEQ_W'(count_reg));
    assign out_p1    = {1'b0, outstanding} + (SEQ_W+1)'(1);
    assign fill_cont = (out_p1 < (SEQ_W+1)'(win_eff)) && (out_p1 < (SEQ_W+1)'(count_reg));

    assign rs_last  = (SEQ_W'(rs_idx_reg) + SEQ_W'(1)) == outstanding;
    assign out_free = !m_valid_reg || m_tready;
    assign s_tready = (state_reg == ST_IDLE);

    // sequencer
    always_comb begin
        state_next   = state_reg;
        head_next    = head_reg;
        count_next   = count_reg;
        base_next    = base_reg;
        nseq_next    = nseq_reg;
        elapsed_next = elapsed_reg;
        running_next = running_reg;
        rs_idx_next  = rs_idx_reg;
        mode_next    = mode_reg;
        pay_in_next  = pay_in_reg;
        fin_in_next  = fin_in_reg;
        ack_in_next  = ack_in_reg;
        ms_in_next   = ms_in_reg;
        mem_we       = 1'b0;
        mem_waddr    = wrap(SUM_W'(head_reg) + SUM_W'(count_reg));
        mem_re       = 1'b0;
        mem_raddr    = wrap(SUM_W'(head_reg) + SUM_W'(outstanding[CNT_W-1:0]));
        out_load     = 1'b0;
        out_kind     = mem_rdata[PAYLOAD_W] ? KIND_FIN : KIND_DATA;
        out_seq      = nseq_reg;
        out_pay      = mem_rdata[PAYLOAD_W-1:0];
        out_last     = 1'b0;

        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    mode_next   = mode_t'(s_tuser[1:0]);
                    fin_in_next = s_tuser[2];
                    pay_in_next = s_tdata[15:0];
                    ack_in_next = s_tdata[31:16];
                    ms_in_next  = s_tdata[47:32];
                    state_next  = ST_DECODE;
                end
            end

            ST_DECODE: begin
                unique case (mode_reg)
                    MODE_ENQUEUE: begin
                        if (count_reg == CNT_W'(RING_DEPTH)) begin
                            // full ring: single refused record
                            if (out_free) begin
                                out_load   = 1'b1;
                                out_kind   = KIND_REFUSED;
                                out_seq    = '0;
                                out_pay    = '0;
                                out_last   = 1'b1;
                                state_next = ST_IDLE;
                            end
                        end else begin
                            mem_we     = 1'b1;
                            count_next = count_reg + CNT_W'(1);
                            state_next = ST_FILL_CHK;
                        end
                    end
                    MODE_ACK_RX: begin
                        if (ack_off < outstanding) begin
                            head_next    = wrap(SUM_W'(head_reg) + SUM_W'(freed));
                            count_next   = count_reg - freed;
                            base_next    = ack_in_reg + SEQ_W'(1);
                            elapsed_next = '0;
                            running_next = 1'b1;
                            state_next   = ST_FILL_CHK;
                        end else begin
                            state_next = ST_IDLE;
                        end
                    end
                    MODE_TICK: begin
                        state_next = ST_IDLE;
                        if (running_reg) begin
                            elapsed_next = tick_sat;
                            if (tick_sat >= {1'b0, timeout_reg}) begin
                                // timeout: restart and resend whole window
                                elapsed_next = '0;
                                running_next = 1'b1;
                                rs_idx_next  = '0;
                                if (outstanding != '0) state_next = ST_RS_RD;
                            end
                        end
                    end
                    MODE_ACK_TX: begin
                        if (out_free) begin
                            out_load   = 1'b1;
                            out_kind   = KIND_ACK;
                            out_seq    = ack_in_reg;
                            out_pay    = '0;
                            out_last   = 1'b1;
                            state_next = ST_IDLE;
                        end
                    end
                endcase
            end

            ST_FILL_CHK: begin
                if (fill_more) begin
                    if (outstanding == '0) begin
                        elapsed_next = '0;
                        running_next = 1'b1;
                    end
                    mem_re     = 1'b1;
                    state_next = ST_FILL_EMIT;
                end else begin
                    if (outstanding == '0) begin
                        elapsed_next = '0;
                        running_next = 1'b0;
                    end
                    state_next = ST_IDLE;
                end
            end

            ST_FILL_EMIT: begin
                if (out_free) begin
                    out_load   = 1'b1;
                    out_last   = !fill_cont;
                    nseq_next  = nseq_reg + SEQ_W'(1);
                    state_next = ST_FILL_CHK;
                end
            end

            ST_RS_RD: begin
                mem_re     = 1'b1;
                mem_raddr  = wrap(SUM_W'(head_reg) + SUM_W'(rs_idx_reg));
                state_next = ST_RS_EMIT;
            end

            ST_RS_EMIT: begin
                if (out_free) begin
                    out_load    = 1'b1;
                    out_seq     = base_reg + SEQ_W'(rs_idx_reg);
                    out_last    = rs_last;
                    rs_idx_next = rs_idx_reg + CNT_W'(1);
                    state_next  = rs_last ? ST_IDLE : ST_RS_RD;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            head_reg    <= '0;
            count_reg   <= '0;
            base_reg    <= '0;
            nseq_reg    <= '0;
            elapsed_reg <= '0;
            running_reg <= 1'b0;
            rs_idx_reg  <= '0;
        end else begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            base_reg    <= base_next;
            nseq_reg    <= nseq_next;
            elapsed_reg <= elapsed_next;
            running_reg <= running_next;
            rs_idx_reg  <= rs_idx_next;
        end
    end

    // latched input word, no reset needed
    always_ff @(posedge aclk) begin
        mode_reg   <= mode_next;
        pay_in_reg <= pay_in_next;
        fin_in_reg <= fin_in_next;
        ack_in_reg <= ack_in_next;
        ms_in_reg  <= ms_in_next;
    end

    // configuration writes
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            window_reg  <= WINDOW_SIZE_RST;
            timeout_reg <= TIMEOUT_MS_RST;
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                CFG_WINDOW_SIZE: window_reg  <= cfg_wdata[WIN_W-1:0];
                CFG_TIMEOUT_MS:  timeout_reg <= cfg_wdata[TIME_W-1:0];
            endcase
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_kind_reg <= out_kind;
            m_seq_reg  <= out_seq;
            m_pay_reg  <= out_pay;
            m_last_reg <= out_last;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_pay_reg, m_seq_reg};
    assign m_tuser  = m_kind_reg;
    assign m_tlast  = m_last_reg;

endmodule : go_back_n_sender_window
`default_nettype wire

// ===== hdl/gbnsw_ring.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbnsw_ring
// Frame ring storage: one write port, one registered read port.
// ----------------------------------------------------------------------------
module gbnsw_ring #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6,
    parameter int DATA_W = 17
) (
    input  wire logic              aclk,
    input  wire logic              wr_en,
    input  wire logic [ADDR_W-1:0] wr_addr,
    input  wire logic [DATA_W-1:0] wr_data,
    input  wire logic              rd_en,
    input  wire logic [ADDR_W-1:0] rd_addr,
    output logic      [DATA_W-1:0] rd_data
);

    logic [DATA_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule : gbnsw_ring
`default_nettype wire

// ===== hdl/gbnsw_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gbnsw_checker
// Port-level checks of the go-back-n sender window.
// ----------------------------------------------------------------------------
module gbnsw_checker
    import gbnsw_pkg::*;
(
    input wire logic                 aclk,
    input wire logic                 aresetn,
    input wire logic                 s_tvalid,
    input wire logic                 s_tready,
    input wire logic [S_TDATA_W-1:0] s_tdata,
    input wire logic [S_TUSER_W-1:0] s_tuser,
    input wire logic                 m_tvalid,
    input wire logic                 m_tready,
    input wire logic [M_TDATA_W-1:0] m_tdata,
    input wire logic [M_TUSER_W-1:0] m_tuser,
    input wire logic                 m_tlast
);

    // stalled word holds
    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed under stall");

    // refused enqueue is a lone, empty record
    a_refused: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_REFUSED) |-> m_tlast && (m_tdata == '0))
        else $error("refused record malformed");

    // own ack is a lone record without payload
    a_ack_tx: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == KIND_ACK) |-> m_tlast && (m_tdata[31:16] == '0))
        else $error("ack record malformed");

    // reset empties the output register
    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

endmodule : gbnsw_checker

bind go_back_n_sender_window gbnsw_checker u_gbnsw_checker (.*);
`default_nettype wire
